/* rtl/fsp_pkg.sv */
// Package: shared types, constants and helpers for the FASTA record parser.
`timescale 1ns / 1ps

package fsp_pkg;

    // Width of the internal nucleotide counter (saturating).
    localparam int COUNT_BITS = 32;
    // Width of the count reported on a close result.
    localparam int SEQ_COUNT_W = 32;

    localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_NL    = 8'h0A;  // '\n'
    localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_NUC   = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [3:0] NUC_INVALID = 4'd15;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_NAME,
        MODE_NAME_NL,
        MODE_SEQ,
        MODE_SEQ_NL
    } t_mode;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             value;
        logic [SEQ_COUNT_W-1:0] seq_count;
        logic                   run_last;
    } t_result;

    // Results of one byte, in delivery order.
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_step_out;

    localparam t_count COUNT_MAX = '1;

    // IUPAC code of a byte, case folded; NUC_INVALID when not a code.
    function automatic logic [3:0] nuc_code(input logic [7:0] b);
        logic [7:0] u;
        logic [3:0] c;
        u = ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'd32) : b;
        case (u)
            8'h41:   c = 4'd0;   // A
            8'h43:   c = 4'd1;   // C
            8'h47:   c = 4'd2;   // G
            8'h54:   c = 4'd3;   // T
            8'h52:   c = 4'd4;   // R
            8'h59:   c = 4'd5;   // Y
            8'h4B:   c = 4'd6;   // K
            8'h4D:   c = 4'd7;   // M
            8'h53:   c = 4'd8;   // S
            8'h57:   c = 4'd9;   // W
            8'h42:   c = 4'd10;  // B
            8'h44:   c = 4'd11;  // D
            8'h48:   c = 4'd12;  // H
            8'h56:   c = 4'd13;  // V
            8'h4E:   c = 4'd14;  // N
            default: c = NUC_INVALID;
        endcase
        return c;
    endfunction

    // Reported count, clamped to the output width.
    function automatic logic [SEQ_COUNT_W-1:0] sat_count(input t_count c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'({SEQ_COUNT_W{1'b1}})) ? {SEQ_COUNT_W{1'b1}} : w[SEQ_COUNT_W-1:0];
    endfunction

endpackage

/* rtl/fsp_if.sv */
// Interfaces: byte request channel and result request channel.
`timescale 1ns / 1ps

interface fsp_in_if
    import fsp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface fsp_out_if
    import fsp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [7:0]             value;
    logic [SEQ_COUNT_W-1:0] seq_count;
    logic                   run_last;

    modport source (output valid, output kind, output value, output seq_count,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input value, input seq_count,
                    input run_last, output ready);
endinterface

/* rtl/fsp_step.sv */
// Per-byte parse logic: next mode, next count and the results of one byte.
`timescale 1ns / 1ps

module fsp_step
    import fsp_pkg::*;
(
    input  t_mode      i_mode,
    input  t_count     i_count,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_mode      o_mode,
    output t_count     o_count,
    output t_step_out  o_res
);

    logic       is_nl;
    logic       is_gt;
    logic [3:0] code;
    logic       code_ok;
    t_count     count_inc;
    t_mode      mode_a;
    t_count     count_a;

    assign is_nl     = (i_byte == CHAR_NL);
    assign is_gt     = (i_byte == CHAR_GT);
    assign code      = nuc_code(i_byte);
    assign code_ok   = (code != NUC_INVALID);
    assign count_inc = (i_count != COUNT_MAX) ? (i_count + t_count'(1)) : i_count;

    // Next state
    always_comb begin
        mode_a  = i_mode;
        count_a = i_count;
        case (i_mode)
            MODE_NAME: begin
                mode_a = is_nl ? MODE_NAME_NL : MODE_NAME;
            end
            MODE_NAME_NL, MODE_SEQ, MODE_SEQ_NL: begin
                if (is_gt && (i_mode != MODE_SEQ)) begin
                    mode_a = MODE_NAME;
                    if (i_mode == MODE_SEQ_NL) begin
                        count_a = '0;
                    end
                end else if (is_nl) begin
                    mode_a = MODE_SEQ_NL;
                end else begin
                    mode_a = MODE_SEQ;
                    if (code_ok) begin
                        count_a = count_inc;
                    end
                end
            end
            default: begin
                if (is_gt) begin
                    mode_a  = MODE_NAME;
                    count_a = '0;
                end else begin
                    mode_a = MODE_SKIP;
                end
            end
        endcase
        o_mode  = i_last ? MODE_SKIP : mode_a;
        o_count = i_last ? '0 : count_a;
    end

    // Results
    always_comb begin
        logic    a_valid;
        logic    c_valid;
        t_result a;
        t_result c;
        a_valid     = 1'b0;
        a           = '0;
        c           = '0;
        c.kind      = KIND_CLOSE;
        c.seq_count = sat_count(count_a);
        c.run_last  = 1'b1;
        c_valid     = i_last && (mode_a != MODE_SKIP);
        case (i_mode)
            MODE_NAME: begin
                a_valid = !is_nl;
                a.kind  = KIND_NAME;
                a.value = i_byte;
            end
            MODE_NAME_NL, MODE_SEQ, MODE_SEQ_NL: begin
                if (is_gt && (i_mode == MODE_NAME_NL)) begin
                    a_valid = 1'b1;
                    a.kind  = KIND_NAME;
                    a.value = CHAR_SPACE;
                end else if (is_gt && (i_mode == MODE_SEQ_NL)) begin
                    a_valid     = 1'b1;
                    a.kind      = KIND_CLOSE;
                    a.seq_count = sat_count(i_count);
                end else begin
                    a_valid = !is_nl && code_ok;
                    a.kind  = KIND_NUC;
                    a.value = {4'd0, code};
                end
            end
            default: begin
                a_valid = 1'b0;
            end
        endcase
        a.run_last = !c_valid;
        o_res.num  = {1'b0, a_valid} + {1'b0, c_valid};
        o_res.res0 = a_valid ? a : c;
        o_res.res1 = c;
    end

endmodule

/* rtl/fsp_queue.sv */
// Result queue: four entries, takes up to two results a cycle, gives one.
`timescale 1ns / 1ps

module fsp_queue
    import fsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_step_out i_res,
    input  logic      i_pop,
    output logic      o_room,
    output logic      o_valid,
    output t_result   o_head
);

    localparam int Depth = 4;

    t_result    r_q [Depth];
    t_result    n_q [Depth];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [2:0] base;
    logic [2:0] add;
    logic       pop_ok;

    assign pop_ok  = i_pop && (r_cnt != 3'd0);
    assign base    = r_cnt - {2'd0, pop_ok};
    assign add     = i_push ? {1'b0, i_res.num} : 3'd0;
    assign n_cnt   = base + add;
    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_head  = r_q[0];

    always_comb begin
        for (int i = 0; i < Depth; i++) begin
            if (pop_ok && (i < Depth - 1)) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if ((add != 3'd0) && (3'(i) == base)) begin
                n_q[i] = i_res.res0;
            end
            if ((add == 3'd2) && (3'(i) == base + 3'd1)) begin
                n_q[i] = i_res.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Depth; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

/* rtl/fasta_record_parser.sv */
// Top level: FASTA record parser, one text byte per request.
`timescale 1ns / 1ps

// FASTA record parser. Takes one byte of FASTA text per input request and
// emits name characters, IUPAC nucleotide codes (A=0 .. N=14, case folded,
// invalid bytes dropped) and a record-closed result that carries the
// saturating nucleotide count. A byte gives zero, one or two results; the
// last result of each byte has run_last set. Parse state (mode and count)
// updates in the same cycle a byte is accepted, and the results land in a
// four-entry result queue, so a byte can be taken every cycle as long as the
// queue holds at most two entries. Sustained rate: one byte per cycle while
// each byte gives at most one result and output ready stays high; bytes that
// give two results are bounded by the output side at one result per cycle.
// Input ready depends only on the queue fill, never on the output ready of
// the same cycle. No configuration.

module fasta_record_parser
    import fsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fsp_in_if.sink    i_in,
    fsp_out_if.source o_out
);

    t_mode     r_mode;
    t_mode     n_mode;
    t_count    r_count;
    t_count    n_count;
    t_step_out step_res;
    t_result   head;
    logic      room;
    logic      accept;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    // Byte decode and state update
    fsp_step u_step (
        .i_mode  (r_mode),
        .i_count (r_count),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.stream_end),
        .o_mode  (n_mode),
        .o_count (n_count),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SKIP;
            r_count <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Result buffering toward the output channel
    fsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (step_res),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_head  (head)
    );

    assign o_out.kind      = head.kind;
    assign o_out.value     = head.value;
    assign o_out.seq_count = head.seq_count;
    assign o_out.run_last  = head.run_last;

endmodule

/* tb/sv/tb_fasta_record_parser.sv */
// Testbench for the FASTA record parser: directed table, random records, checked results.
`timescale 1ns / 1ps

module tb_fasta_record_parser;
    import fsp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 450;

    // One stimulus row. When typed is set, n/r0/r1 hold the expected results
    // written by hand; otherwise the parse predictor supplies them.
    typedef struct packed {
        logic [7:0] b;
        logic       e;
        logic       typed;
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_stim_row;

    localparam t_result NO_RESULT = '0;

    localparam logic [7:0] NUC_LETTERS [15] = '{
        "A", "C", "G", "T", "R", "Y", "K", "M", "S", "W", "B", "D", "H", "V", "N"
    };

    // Directed rows: extremes of the byte, all result kinds, name continuation,
    // newline runs, case folding, dropped bytes and streams that end in skip, in sequence and on '>'.
    t_stim_row dir_table [27] = '{
        '{8'h78,      1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT},                  // skipped
        '{CHAR_GT,    1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT},                  // opens
        '{8'h00,      1'b0, 1'b1, 2'd1, '{KIND_NAME, 8'h00, 32'd0, 1'b1}, NO_RESULT},
        '{8'hFF,      1'b0, 1'b1, 2'd1, '{KIND_NAME, 8'hFF, 32'd0, 1'b1}, NO_RESULT},
        '{CHAR_NL,    1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
        '{CHAR_GT,    1'b0, 1'b1, 2'd1, '{KIND_NAME, CHAR_SPACE, 32'd0, 1'b1}, NO_RESULT},
        '{8'h41,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // 'A' in name
        '{CHAR_NL,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CHAR_NL,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // seq newline
        '{CHAR_NL,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'h61,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // 'a'
        '{8'h6E,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // 'n'
        '{8'hC1,      1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT},                  // high byte
        '{8'h58,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // 'X'
        '{CHAR_NL,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CHAR_GT,    1'b0, 1'b1, 2'd1, '{KIND_CLOSE, 8'h00, 32'd2, 1'b1}, NO_RESULT},
        '{8'h71,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // 'q'
        '{CHAR_NL,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'h67,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // 'g' as seq
        '{8'h54,      1'b1, 1'b1, 2'd2, '{KIND_NUC, 8'd3, 32'd0, 1'b0},
                                        '{KIND_CLOSE, 8'h00, 32'd2, 1'b1}},
        '{CHAR_GT,    1'b1, 1'b1, 2'd1, '{KIND_CLOSE, 8'h00, 32'd0, 1'b1}, NO_RESULT},
        '{8'h7A,      1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT},                  // end in skip
        '{CHAR_GT,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CHAR_NL,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'h63,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},                  // 'c'
        '{CHAR_NL,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CHAR_GT,    1'b1, 1'b1, 2'd2, '{KIND_CLOSE, 8'h00, 32'd1, 1'b0},
                                        '{KIND_CLOSE, 8'h00, 32'd0, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;

    fsp_in_if  in_if ();
    fsp_out_if out_if ();

    fasta_record_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    t_mode  parse_st;
    t_count nuc_total;

    // Expected results in delivery order, and bookkeeping
    t_result    want_q [$];
    t_stim_row  plan_q [$];
    t_stim_row  cur_row;
    int         mismatches   = 0;
    int         bytes_taken  = 0;
    int         results_seen = 0;
    int         closes_seen  = 0;
    int         cycle_no     = 0;
    int         idle_pct     = 0;
    int         stall_pct    = 0;
    int         hold_left    = 0;

    // Append at the tail of the expected-result queue.
    function automatic void want_add(input t_result r);
        want_q.insert(want_q.size(), r);
    endfunction

    // Append at the tail of the stimulus plan.
    function automatic void plan_add(input t_stim_row row);
        plan_q.insert(plan_q.size(), row);
    endfunction

    function automatic t_result close_of(input t_count c);
        t_result     r;
        logic [63:0] w;
        w = 64'(c);
        r = '0;
        r.kind = KIND_CLOSE;
        r.seq_count = (w > 64'({SEQ_COUNT_W{1'b1}})) ? {SEQ_COUNT_W{1'b1}} : w[SEQ_COUNT_W-1:0];
        return r;
    endfunction

    // Advance the parse state by one byte; returns the results that byte gives.
    task automatic parse_byte(input logic [7:0] b, input logic e,
                              output t_result r [2], output int n);
        t_result    rs [2];
        int         k;
        int         i;
        logic       to_seq;
        logic [7:0] up;
        logic [3:0] code;
        rs[0] = '0;
        rs[1] = '0;
        k = 0;
        to_seq = 1'b0;
        case (parse_st)
            MODE_NAME: begin
                if (b == CHAR_NL) begin
                    parse_st = MODE_NAME_NL;
                end else begin
                    rs[k] = '{KIND_NAME, b, '0, 1'b0};
                    k++;
                end
            end
            MODE_NAME_NL: begin
                if (b == CHAR_GT) begin
                    parse_st = MODE_NAME;
                    rs[k] = '{KIND_NAME, CHAR_SPACE, '0, 1'b0};
                    k++;
                end else begin
                    to_seq = 1'b1;
                end
            end
            MODE_SEQ: begin
                to_seq = 1'b1;
            end
            MODE_SEQ_NL: begin
                if (b == CHAR_GT) begin
                    rs[k] = close_of(nuc_total);
                    k++;
                    nuc_total = '0;
                    parse_st = MODE_NAME;
                end else begin
                    to_seq = 1'b1;
                end
            end
            default: begin
                if (b == CHAR_GT) begin
                    nuc_total = '0;
                    parse_st = MODE_NAME;
                end else begin
                    parse_st = MODE_SKIP;
                end
            end
        endcase
        if (to_seq) begin
            if (b == CHAR_NL) begin
                parse_st = MODE_SEQ_NL;
            end else begin
                parse_st = MODE_SEQ;
                up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
                code = NUC_INVALID;
                for (i = 0; i < 15; i++)
                    if (up == NUC_LETTERS[i]) code = 4'(i);
                if (code != NUC_INVALID) begin
                    if (nuc_total != COUNT_MAX) nuc_total++;
                    rs[k] = '{KIND_NUC, {4'd0, code}, '0, 1'b0};
                    k++;
                end
            end
        end
        // Final byte of the stream closes any open record
        if (e) begin
            if (parse_st != MODE_SKIP) begin
                rs[k] = close_of(nuc_total);
                k++;
            end
            parse_st = MODE_SKIP;
            nuc_total = '0;
        end
        if (k > 0) rs[k-1].run_last = 1'b1;
        r = rs;
        n = k;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Sample both channels at the rising edge.
    always @(posedge clk) begin
        t_result pr [2];
        int      pn;
        int      i;
        t_result got;
        t_result exp_r;
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_no, want_q.size());
            $display("fasta_record_parser: mismatch");
            $finish;
        end
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                parse_byte(in_if.in_byte, in_if.stream_end, pr, pn);
                bytes_taken++;
                if (cur_row.typed) begin
                    if (cur_row.n >= 2'd1) want_add(cur_row.r0);
                    if (cur_row.n >= 2'd2) want_add(cur_row.r1);
                end else begin
                    for (i = 0; i < pn; i++) want_add(pr[i]);
                end
            end
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.kind, out_if.value, out_if.seq_count, out_if.run_last};
                results_seen++;
                if (got.kind == KIND_CLOSE) closes_seen++;
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    exp_r = want_q.pop_front();
                    check_field("kind", 32'(exp_r.kind), 32'(got.kind));
                    check_field("value", 32'(exp_r.value), 32'(got.value));
                    check_field("seq_count", 32'(exp_r.seq_count), 32'(got.seq_count));
                    check_field("run_last", 32'(exp_r.run_last), 32'(got.run_last));
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold when one is requested.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one byte request, starting and ending at a falling edge.
    task automatic send_row(input t_stim_row row);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        cur_row = row;
        in_if.valid      <= 1'b1;
        in_if.in_byte    <= row.b;
        in_if.stream_end <= row.e;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic plan_byte(input logic [7:0] b, input logic e);
        plan_add('{b, e, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
    endtask

    // Mostly well-formed records with random content; some raw noise.
    task automatic plan_chunk();
        int         len;
        int         lines;
        int         i;
        int         j;
        logic [7:0] c;
        t_stim_row  tail;
        if ($urandom_range(99) < 12) begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
                plan_byte(8'($urandom_range(255)), ($urandom_range(19) == 0));
        end else begin
            plan_byte(CHAR_GT, 1'b0);
            len = $urandom_range(0, 10);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0) begin
                    plan_byte(CHAR_NL, 1'b0);   // continued header line
                    plan_byte(CHAR_GT, 1'b0);
                end else begin
                    plan_byte(8'($urandom_range(255)), 1'b0);
                end
            end
            plan_byte(CHAR_NL, 1'b0);
            lines = $urandom_range(0, 3);
            for (i = 0; i < lines; i++) begin
                len = $urandom_range(0, 24);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(99) < 85) begin
                        c = NUC_LETTERS[$urandom_range(14)];
                        if ($urandom_range(1) == 1) c = c | 8'h20;
                    end else begin
                        c = 8'($urandom_range(255));
                    end
                    plan_byte(c, 1'b0);
                end
                plan_byte(CHAR_NL, 1'b0);
                if ($urandom_range(7) == 0) plan_byte(CHAR_NL, 1'b0);
            end
            // Sometimes the record's last byte also ends the stream
            if ($urandom_range(3) == 0) begin
                tail = plan_q.pop_back();
                tail.e = 1'b1;
                plan_add(tail);
            end
        end
    endtask

    // Stop offering and let every expected result come out.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (want_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        int p;
        int i;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.stream_end = 1'b0;
        cur_row = '0;
        parse_st = MODE_SKIP;
        nuc_total = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < 27; i++) send_row(dir_table[i]);
        drain();

        // Phases: free running after one long output hold, sparse input, stalled output, both
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  hold_left = 300; end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            plan_q.delete();
            while (plan_q.size() < PHASE_BYTES) plan_chunk();
            foreach (plan_q[i]) send_row(plan_q[i]);
            drain();
        end

        $display("sent %0d bytes: directed rows, then random records in four idle/stall mixes",
                 bytes_taken);
        $display("checked %0d results including %0d record closes, with one long output hold",
                 results_seen, closes_seen);
        if (mismatches == 0 && want_q.size() == 0) begin
            $display("fasta_record_parser: match");
        end else begin
            $display("fasta_record_parser: mismatch");
        end
        $finish;
    end

endmodule
